FILE: rtl/htpd_pkg.sv
// Shared constants and types for the humidity/temperature pulse decoder.
package htpd_pkg;

	localparam int unsigned WIDTH_W      = 16;
	localparam int unsigned POS_W        = 6;
	localparam int unsigned FRAME_PULSES = 40;
	localparam int unsigned TEMP_START   = 16;
	localparam int unsigned CSUM_START   = 32;
	localparam int unsigned HUM_LIMIT    = 101;
	localparam int unsigned TEMP_LIMIT   = 81;
	localparam int unsigned EMPTY_SLOT   = 255;

	// x / 10 == (x * 52429) >> 19 for any 16-bit x
	localparam int unsigned DIV10_MUL    = 52429;
	localparam int unsigned DIV10_SHIFT  = 19;
	// s / 3 == (s * 683) >> 11 for s below 1024
	localparam int unsigned DIV3_MUL     = 683;
	localparam int unsigned DIV3_SHIFT   = 11;

	localparam int unsigned CFG_IDX_W    = 2;
	localparam logic [CFG_IDX_W-1:0] REG_ZERO_MIN = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ZERO_MAX = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ONE_MIN  = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_ONE_MAX  = 2'd3;

	localparam int unsigned QUEUE_DEPTH  = 4;
	localparam int unsigned QUEUE_PTR_W  = 2;

	typedef struct packed {
		logic [15:0] hum;
		logic [15:0] temp;
		logic        csum_ok;
	} frame_t;

endpackage

FILE: rtl/htpd_front.sv
// Front end: pulse classification, field shifting and end-of-frame checksum.
module htpd_front import htpd_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [15:0]          s_tdata,   // [15:0] pulse_width
	input  logic                 s_tuser,   // [0] frame_start
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [15:0]          cfg_data,
	input  logic                 q_full,
	output logic                 q_push,
	output frame_t               q_frame
);

	logic [15:0]      zero_min_q, zero_max_q, one_min_q, one_max_q;
	logic [POS_W-1:0] pos_q;
	logic [15:0]      hum_q, temp_q;
	logic [7:0]       csum_q;
	logic             neg_q;

	logic             accept;
	logic [POS_W-1:0] pos;
	logic             is_zero, in_one, is_one, hit, frame_end;
	logic [15:0]      hum_d, temp_d, temp_fin;
	logic [7:0]       csum_d, sum;
	logic             neg_d, neg_fin, ok;

	assign cfg_ready = 1'b1;
	assign s_tready  = !q_full || (pos_q != POS_W'(FRAME_PULSES - 1));
	assign accept    = s_tvalid && s_tready;

	always_comb begin
		pos       = s_tuser ? '0 : pos_q;
		is_zero   = (s_tdata >= zero_min_q) && (s_tdata <= zero_max_q);
		in_one    = (s_tdata >= one_min_q) && (s_tdata <= one_max_q);
		is_one    = !is_zero && in_one;
		hit       = is_zero || is_one;
		frame_end = (pos == POS_W'(FRAME_PULSES - 1));
		hum_d     = hum_q;
		temp_d    = temp_q;
		csum_d    = csum_q;
		neg_d     = neg_q || ((pos == POS_W'(TEMP_START)) && in_one);
		if (hit) begin
			if (pos < POS_W'(TEMP_START)) begin
				hum_d = {hum_q[14:0], is_one};
			end else if (pos < POS_W'(CSUM_START)) begin
				temp_d = {temp_q[14:0], is_one};
			end else begin
				csum_d = {csum_q[6:0], is_one};
			end
		end
		sum      = hum_d[7:0] + hum_d[15:8] + temp_d[7:0] + temp_d[15:8];
		ok       = (sum == csum_d);
		temp_fin = temp_d;
		neg_fin  = neg_d;
		if (frame_end && ok && neg_d) begin
			temp_fin = '0;
			neg_fin  = 1'b0;
		end
	end

	assign q_push          = accept && frame_end;
	assign q_frame.hum     = hum_d;
	assign q_frame.temp    = temp_fin;
	assign q_frame.csum_ok = ok;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			zero_min_q <= 16'd22;
			zero_max_q <= 16'd32;
			one_min_q  <= 16'd68;
			one_max_q  <= 16'd75;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_ZERO_MIN: zero_min_q <= cfg_data;
				REG_ZERO_MAX: zero_max_q <= cfg_data;
				REG_ONE_MIN:  one_min_q  <= cfg_data;
				REG_ONE_MAX:  one_max_q  <= cfg_data;
				default:      ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q  <= '0;
			hum_q  <= '0;
			temp_q <= '0;
			csum_q <= '0;
			neg_q  <= 1'b0;
		end else if (accept) begin
			pos_q  <= frame_end ? '0 : pos + POS_W'(1);
			hum_q  <= hum_d;
			temp_q <= temp_fin;
			csum_q <= csum_d;
			neg_q  <= neg_fin;
		end
	end

	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q < POS_W'(FRAME_PULSES))
		else $error("pulse position beyond frame");

endmodule

FILE: rtl/htpd_queue.sv
// Short frame queue between front and back ends.
module htpd_queue import htpd_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   push,
	input  frame_t push_frame,
	output logic   full,
	input  logic   pop,
	output logic   empty,
	output frame_t pop_frame
);

	frame_t                 slot_q [QUEUE_DEPTH];
	logic [QUEUE_PTR_W-1:0] wr_q, rd_q;
	logic [QUEUE_PTR_W:0]   cnt_q;

	assign full      = (cnt_q == (QUEUE_PTR_W+1)'(QUEUE_DEPTH));
	assign empty     = (cnt_q == '0);
	assign pop_frame = slot_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_q] <= push_frame;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + QUEUE_PTR_W'(1);
			end
			if (pop) begin
				rd_q <= rd_q + QUEUE_PTR_W'(1);
			end
			unique case ({push, pop})
				2'b10:   cnt_q <= cnt_q + (QUEUE_PTR_W+1)'(1);
				2'b01:   cnt_q <= cnt_q - (QUEUE_PTR_W+1)'(1);
				default: ;
			endcase
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> !push)
		else $error("queue overflow");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		empty |-> !pop)
		else $error("queue underflow");

endmodule

FILE: rtl/htpd_back.sv
// Back end: scaling, range check, history averaging and result register.
module htpd_back import htpd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        q_empty,
	output logic        q_pop,
	input  frame_t      q_frame,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata   // [7:0] humidity, [15:8] temperature,
	                              // [16] checksum_ok, [17] in_range, [18] averaged
);

	logic        adv;
	logic [31:0] hprod, tprod;

	logic        vld_s1, ok_s1;
	logic [12:0] h_s1, t_s1;

	logic        vld_s2, ok_s2, rng_s2, avg_s2;
	logic [6:0]  h_s2, t_s2;
	logic [9:0]  hsum_s2, tsum_s2;

	logic [7:0]  h_old_q, h_new_q, t_old_q, t_new_q;
	logic [7:0]  held_h_q, held_t_q;
	logic        ok_q, rng_q, avg_q, out_vld_q;

	logic        rng, avail;
	logic [9:0]  hsum, tsum;
	logic [19:0] hq, tq;

	assign adv   = !out_vld_q || m_tready;
	assign q_pop = adv && !q_empty;

	assign hprod = {16'd0, q_frame.hum}  * 32'(DIV10_MUL);
	assign tprod = {16'd0, q_frame.temp} * 32'(DIV10_MUL);

	always_comb begin
		rng   = ok_s1 && (h_s1 < 13'(HUM_LIMIT)) && (t_s1 < 13'(TEMP_LIMIT));
		avail = (h_old_q != 8'(EMPTY_SLOT)) && (h_new_q != 8'(EMPTY_SLOT));
		hsum  = {3'd0, h_s1[6:0]} + {2'd0, h_old_q} + {2'd0, h_new_q};
		tsum  = {3'd0, t_s1[6:0]} + {2'd0, t_old_q} + {2'd0, t_new_q};
		hq    = hsum_s2 * 10'(DIV3_MUL);
		tq    = tsum_s2 * 10'(DIV3_MUL);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			h_s1    <= hprod[31:DIV10_SHIFT];
			t_s1    <= tprod[31:DIV10_SHIFT];
			ok_s1   <= q_frame.csum_ok;
			ok_s2   <= ok_s1;
			rng_s2  <= rng;
			avg_s2  <= rng && avail;
			h_s2    <= h_s1[6:0];
			t_s2    <= t_s1[6:0];
			hsum_s2 <= hsum;
			tsum_s2 <= tsum;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1    <= 1'b0;
			vld_s2    <= 1'b0;
			out_vld_q <= 1'b0;
			h_old_q   <= 8'(EMPTY_SLOT);
			h_new_q   <= 8'(EMPTY_SLOT);
			t_old_q   <= 8'(EMPTY_SLOT);
			t_new_q   <= 8'(EMPTY_SLOT);
			held_h_q  <= '0;
			held_t_q  <= '0;
			ok_q      <= 1'b0;
			rng_q     <= 1'b0;
			avg_q     <= 1'b0;
		end else if (adv) begin
			vld_s1    <= q_pop;
			vld_s2    <= vld_s1;
			out_vld_q <= vld_s2;
			if (vld_s1 && rng) begin
				h_old_q <= h_new_q;
				h_new_q <= {1'b0, h_s1[6:0]};
				t_old_q <= t_new_q;
				t_new_q <= {1'b0, t_s1[6:0]};
			end
			if (vld_s2) begin
				ok_q  <= ok_s2;
				rng_q <= rng_s2;
				avg_q <= avg_s2;
				if (rng_s2) begin
					held_h_q <= avg_s2 ? hq[DIV3_SHIFT+7:DIV3_SHIFT] : {1'b0, h_s2};
					held_t_q <= avg_s2 ? tq[DIV3_SHIFT+7:DIV3_SHIFT] : {1'b0, t_s2};
				end
			end
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = {5'd0, avg_q, rng_q, ok_q, held_t_q, held_h_q};

	a_hold_stalled: assert property (@(posedge clk) disable iff (!arst_n)
		(out_vld_q && !m_tready) |=> ($stable(held_h_q) && $stable(held_t_q)))
		else $error("held values changed under a stalled beat");

	a_flag_order: assert property (@(posedge clk) disable iff (!arst_n)
		out_vld_q |-> ((!avg_q || rng_q) && (!rng_q || ok_q)))
		else $error("result flags inconsistent");

	a_history_pair: assert property (@(posedge clk) disable iff (!arst_n)
		(h_new_q == 8'(EMPTY_SLOT)) == (t_new_q == 8'(EMPTY_SLOT)))
		else $error("history slots out of step");

endmodule

FILE: rtl/humidity_temp_pulse_decoder.sv
// A frame result passes the queue, stages s1, s2 and the result register.
// Throughput: up to one pulse beat per cycle; one result per 40 pulses.
// The front stalls only while pos_q is 39 and the 4-entry queue is full.
// Reset (arst_n low, asynchronous): windows 22..32 / 68..75, position and shift
// fields cleared, history slots empty (255), held values zero, no result pending.
module humidity_temp_pulse_decoder import htpd_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [15:0]          s_tdata,   // [15:0] pulse_width
	input  logic                 s_tuser,   // [0] frame_start
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [23:0]          m_tdata,   // [7:0] humidity, [15:8] temperature,
	                                        // [16] checksum_ok, [17] in_range, [18] averaged
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [15:0]          cfg_data
);

	logic   q_full, q_empty, q_push, q_pop;
	frame_t push_frame, pop_frame;

	htpd_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.q_full    (q_full),
		.q_push    (q_push),
		.q_frame   (push_frame)
	);

	htpd_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_frame (push_frame),
		.full       (q_full),
		.pop        (q_pop),
		.empty      (q_empty),
		.pop_frame  (pop_frame)
	);

	htpd_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_empty  (q_empty),
		.q_pop    (q_pop),
		.q_frame  (pop_frame),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

endmodule

FILE: bench/tb_humidity_temp_pulse_decoder.sv
// Self-checking bench for the humidity/temperature pulse decoder: scripted and random frames.
`timescale 1ns / 100ps

module tb_humidity_temp_pulse_decoder;
	import htpd_pkg::*;

	localparam int WATCHDOG_LIMIT = 3000;
	localparam int SCALE          = 10;
	localparam int AVG_TAPS       = 3;
	localparam int SCRIPT_ROWS    = 14;

	// result beat as packed in m_tdata[18:0]
	typedef struct packed {
		logic       averaged;
		logic       in_range;
		logic       csum_ok;
		logic [7:0] temp;
		logic [7:0] hum;
	} reading_t;

	typedef struct packed {
		logic [15:0] hum;
		logic [15:0] temp;
		logic [7:0]  csum;
		logic        first_start;
		int          lead;
		int          noise_pos;
		logic [15:0] noise_w;
		logic        pinned;
		reading_t    want;
	} frame_row_t;

	typedef enum {RX_OPEN, RX_COIN, RX_SPARSE, RX_HOLD} rx_mode_t;

	// want columns: averaged, in_range, csum_ok, temp, hum
	localparam frame_row_t SCRIPT [SCRIPT_ROWS] = '{
		'{16'd0,     16'd0,     8'h00, 1'b1, 0,  -1, 16'd0,     1'b1, '{0, 1, 1, 8'd0,  8'd0}},
		'{16'h0001,  16'd0,     8'h00, 1'b1, 0,  -1, 16'd0,     1'b1, '{0, 0, 0, 8'd0,  8'd0}},
		'{16'hFFFF,  16'hFFFF,  8'hFC, 1'b1, 0,  -1, 16'd0,     1'b1, '{0, 0, 1, 8'd0,  8'd0}},
		'{16'd1009,  16'd809,   8'h20, 1'b1, 0,  -1, 16'd0,     1'b1, '{0, 1, 1, 8'd80, 8'd100}},
		'{16'd1010,  16'd0,     8'hF5, 1'b1, 0,  -1, 16'd0,     1'b0, '{0, 0, 0, 8'd0,  8'd0}},
		'{16'd0,     16'd810,   8'h2D, 1'b1, 0,  -1, 16'd0,     1'b0, '{0, 0, 0, 8'd0,  8'd0}},
		'{16'd500,   16'd250,   8'hEF, 1'b1, 0,  -1, 16'd0,     1'b0, '{0, 0, 0, 8'd0,  8'd0}},
		'{16'd600,   16'h8064,  8'h3E, 1'b1, 0,  -1, 16'd0,     1'b0, '{0, 0, 0, 8'd0,  8'd0}},
		'{16'd300,   16'h80C8,  8'h00, 1'b1, 0,  -1, 16'd0,     1'b0, '{0, 0, 0, 8'd0,  8'd0}},
		'{16'd400,   16'h00FA,  8'h8B, 1'b1, 0,  -1, 16'd0,     1'b0, '{0, 0, 0, 8'd0,  8'd0}},
		'{16'd700,   16'h00C8,  8'h86, 1'b1, 0,  5,  16'd0,     1'b0, '{0, 0, 0, 8'd0,  8'd0}},
		'{16'd700,   16'h00C8,  8'h86, 1'b1, 0,  20, 16'hFFFF,  1'b0, '{0, 0, 0, 8'd0,  8'd0}},
		'{16'd700,   16'h00C8,  8'h86, 1'b1, 17, -1, 16'd0,     1'b0, '{0, 0, 0, 8'd0,  8'd0}},
		'{16'd700,   16'h00C8,  8'h86, 1'b0, 0,  -1, 16'd0,     1'b0, '{0, 0, 0, 8'd0,  8'd0}}
	};

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	logic [15:0]          s_tdata = '0;
	logic                 s_tuser = 1'b0;
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	logic [23:0]          m_tdata;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [15:0]          cfg_data = '0;

	// tag travelling with each pulse beat: pins the expected reading of a scripted frame
	logic                 beat_pin = 1'b0;
	reading_t             beat_want = '0;

	// decoder model state
	logic [15:0] zero_lo = 16'd22;
	logic [15:0] zero_hi = 16'd32;
	logic [15:0] one_lo = 16'd68;
	logic [15:0] one_hi = 16'd75;
	logic [5:0]  bit_index = '0;
	logic [15:0] hum_word = '0;
	logic [15:0] temp_word = '0;
	logic [7:0]  sum_byte = '0;
	logic        minus_seen = 1'b0;
	logic [7:0]  hum_old = 8'hFF;
	logic [7:0]  hum_new = 8'hFF;
	logic [7:0]  temp_old = 8'hFF;
	logic [7:0]  temp_new = 8'hFF;
	logic [7:0]  hum_out = '0;
	logic [7:0]  temp_out = '0;

	reading_t readings_due [$];
	int       fail_count = 0;
	int       stall_cycles = 0;
	int       pulses_sent = 0;
	int       burst_left = 0;
	bit       steady = 1'b0;
	rx_mode_t rx_mode = RX_OPEN;
	int       rx_left = 0;

	humidity_temp_pulse_decoder dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	task automatic decode_pulse(input logic [15:0] w, input logic start, output bit done,
			output reading_t r);
		logic [5:0]  p;
		logic        in_zero;
		logic        in_one;
		logic        one_bit;
		logic [7:0]  total;
		int unsigned h;
		int unsigned t;
		r = '0;
		done = 1'b0;
		if (start)
			bit_index = '0;
		p = bit_index;
		in_zero = (w >= zero_lo) && (w <= zero_hi);
		in_one = (w >= one_lo) && (w <= one_hi);
		one_bit = in_one && !in_zero;
		if (p == TEMP_START && in_one)
			minus_seen = 1'b1;
		if (in_zero || in_one) begin
			if (p < TEMP_START)
				hum_word = {hum_word[14:0], one_bit};
			else if (p < CSUM_START)
				temp_word = {temp_word[14:0], one_bit};
			else
				sum_byte = {sum_byte[6:0], one_bit};
		end
		if (p + 1 < FRAME_PULSES) begin
			bit_index = p + 6'd1;
		end else begin
			bit_index = '0;
			done = 1'b1;
			total = hum_word[7:0] + hum_word[15:8] + temp_word[7:0] + temp_word[15:8];
			r.csum_ok = (total == sum_byte);
			if (r.csum_ok) begin
				if (minus_seen) begin
					minus_seen = 1'b0;
					temp_word = '0;
				end
				h = hum_word / SCALE;
				t = temp_word / SCALE;
				if (h < HUM_LIMIT && t < TEMP_LIMIT) begin
					r.in_range = 1'b1;
					if (hum_old != 8'(EMPTY_SLOT) && hum_new != 8'(EMPTY_SLOT)) begin
						r.averaged = 1'b1;
						hum_out = 8'((h + hum_old + hum_new) / AVG_TAPS);
						temp_out = 8'((t + temp_old + temp_new) / AVG_TAPS);
					end else begin
						hum_out = 8'(h);
						temp_out = 8'(t);
					end
					hum_old = hum_new;
					hum_new = 8'(h);
					temp_old = temp_new;
					temp_new = 8'(t);
				end
			end
			r.hum = hum_out;
			r.temp = temp_out;
		end
	endtask

	task automatic compare_field(input string name, input int unsigned want, input int unsigned got);
		if (want != got) begin
			fail_count++;
			$display("%0t: %s expected %0d got %0d", $time, name, want, got);
		end
	endtask

	always @(posedge clk) begin : observe
		bit       done;
		reading_t calc;
		reading_t seen;
		reading_t due;
		if (arst_n) begin
			stall_cycles++;
			if (cfg_valid && cfg_ready) begin
				stall_cycles = 0;
				case (cfg_index)
					REG_ZERO_MIN: zero_lo = cfg_data;
					REG_ZERO_MAX: zero_hi = cfg_data;
					REG_ONE_MIN:  one_lo = cfg_data;
					REG_ONE_MAX:  one_hi = cfg_data;
					default: ;
				endcase
			end
			if (s_tvalid && s_tready) begin
				stall_cycles = 0;
				decode_pulse(s_tdata, s_tuser, done, calc);
				if (done)
					readings_due.push_back(beat_pin ? beat_want : calc);
			end
			if (m_tvalid && m_tready) begin
				stall_cycles = 0;
				seen = reading_t'(m_tdata[18:0]);
				if (readings_due.size() == 0) begin
					fail_count++;
					$display("%0t: result beat with none due, expected nothing got %h",
						$time, m_tdata);
				end else begin
					due = readings_due.pop_front();
					compare_field("humidity", due.hum, seen.hum);
					compare_field("temperature", due.temp, seen.temp);
					compare_field("checksum_ok", due.csum_ok, seen.csum_ok);
					compare_field("in_range", due.in_range, seen.in_range);
					compare_field("averaged", due.averaged, seen.averaged);
					compare_field("padding", 0, m_tdata[23:19]);
				end
			end
		end
	end

	// receiver: runs of open, coin-toss, sparse and held-off ready
	always @(negedge clk) begin
		if (rx_left == 0) begin
			rx_mode = rx_mode_t'($urandom_range(0, 3));
			rx_left = $urandom_range(20, 300);
		end else begin
			rx_left--;
		end
		case (rx_mode)
			RX_OPEN:   m_tready <= 1'b1;
			RX_COIN:   m_tready <= 1'($urandom_range(0, 1));
			RX_SPARSE: m_tready <= ($urandom_range(0, 3) == 0);
			default:   m_tready <= 1'b0;
		endcase
	end

	task automatic send_pulse(input logic [15:0] w, input logic start, input logic pin,
			input reading_t want);
		int gap;
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tdata <= w;
		s_tuser <= start;
		beat_pin <= pin;
		beat_want <= want;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		pulses_sent++;
		if (!steady) begin
			if (burst_left == 0) begin
				burst_left = $urandom_range(1, 24);
				gap = $urandom_range(1, 6);
				@(negedge clk);
				s_tvalid <= 1'b0;
				repeat (gap - 1)
					@(negedge clk);
			end else begin
				burst_left--;
			end
		end
	endtask

	// bits go out MSB first; widths come from the bit's window, save noise or inverted windows
	task automatic send_frame(input logic [15:0] h, input logic [15:0] t, input logic [7:0] c,
			input logic first_start, input int noise_pos, input logic [15:0] noise_w,
			input logic pin, input reading_t want);
		logic        b;
		logic [15:0] w;
		for (int i = 0; i < FRAME_PULSES; i++) begin
			b = (i < TEMP_START) ? h[15 - i] : (i < CSUM_START) ? t[31 - i] : c[39 - i];
			if (i == noise_pos)
				w = noise_w;
			else if (!b && zero_lo <= zero_hi)
				w = 16'($urandom_range(zero_hi, zero_lo));
			else if (b && one_lo <= one_hi)
				w = 16'($urandom_range(one_hi, one_lo));
			else
				w = 16'($urandom);
			send_pulse(w, (i == 0) ? first_start : 1'b0, pin && (i == FRAME_PULSES - 1), want);
		end
	endtask

	task automatic send_lead(input int n);
		for (int i = 0; i < n; i++)
			send_pulse(16'($urandom), ($urandom_range(0, 7) == 0), 1'b0, '0);
	endtask

	// mostly well-formed frames, some corrupt, noisy or cut short by a restart
	task automatic random_frame();
		logic [15:0] h;
		logic [15:0] t;
		logic [7:0]  c;
		int          kind;
		int          spot;
		kind = $urandom_range(0, 9);
		spot = -1;
		if (kind <= 4) begin
			h = 16'($urandom_range(0, 1009));
			t = 16'($urandom_range(0, 809));
			if ($urandom_range(0, 3) == 0)
				t[15] = 1'b1;
		end else begin
			h = 16'($urandom);
			t = 16'($urandom);
		end
		c = h[7:0] + h[15:8] + t[7:0] + t[15:8];
		if (kind == 7)
			c = 8'($urandom);
		if (kind == 8)
			spot = $urandom_range(0, FRAME_PULSES - 1);
		steady = ($urandom_range(0, 3) == 0);
		if (kind == 9)
			send_lead($urandom_range(1, FRAME_PULSES - 1));
		send_frame(h, t, c, (kind == 9) || ($urandom_range(0, 3) != 0), spot, 16'($urandom),
			1'b0, '0);
	endtask

	task automatic run_random(input int budget);
		int target;
		target = pulses_sent + budget;
		while (pulses_sent < target)
			random_frame();
	endtask

	task automatic settle();
		if (s_tvalid) begin
			@(negedge clk);
			s_tvalid <= 1'b0;
		end
		while (readings_due.size() != 0)
			@(posedge clk);
		repeat (8)
			@(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic set_windows(input logic [15:0] zl, input logic [15:0] zh,
			input logic [15:0] ol, input logic [15:0] oh);
		write_reg(REG_ZERO_MIN, zl);
		write_reg(REG_ZERO_MAX, zh);
		write_reg(REG_ONE_MIN, ol);
		write_reg(REG_ONE_MAX, oh);
	endtask

	initial begin
		int unsigned zl;
		int unsigned zh;
		int unsigned ol;
		repeat (8)
			@(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		for (int i = 0; i < SCRIPT_ROWS; i++) begin
			steady = ($urandom_range(0, 1) == 0);
			send_lead(SCRIPT[i].lead);
			send_frame(SCRIPT[i].hum, SCRIPT[i].temp, SCRIPT[i].csum, SCRIPT[i].first_start,
				SCRIPT[i].noise_pos, SCRIPT[i].noise_w, SCRIPT[i].pinned, SCRIPT[i].want);
		end

		// overlapping windows: a width in both reads as zero but still flags negative
		settle();
		set_windows(16'd10, 16'd50, 16'd40, 16'd80);
		for (int i = 0; i < FRAME_PULSES; i++)
			send_pulse(16'd45, (i == 0), 1'b0, '0);
		run_random(120);

		settle();
		set_windows(16'd0, 16'd0, 16'hFFFF, 16'hFFFF);
		run_random(120);

		// inverted bounds: every width falls outside both windows
		settle();
		set_windows(16'hFFFF, 16'd0, 16'd40000, 16'd30000);
		run_random(80);

		repeat (3) begin
			settle();
			zl = $urandom_range(0, 32767);
			zh = zl + $urandom_range(0, 4000);
			ol = $urandom_range(zh, 65535);
			set_windows(16'(zl), 16'(zh), 16'(ol), 16'($urandom_range(ol, 65535)));
			run_random(100);
		end

		settle();
		set_windows(16'd22, 16'd32, 16'd68, 16'd75);
		run_random(250);

		settle();
		if (fail_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

	initial begin
		wait (arst_n);
		while (stall_cycles < WATCHDOG_LIMIT)
			@(posedge clk);
		$display("%0t: watchdog, no beat for %0d cycles", $time, WATCHDOG_LIMIT);
		$display("Regression FAIL");
		$finish;
	end

endmodule
